@@ hdl/xptw_pkg.sv @@
package xptw_pkg;

  typedef struct packed {
    logic        command;
    logic [47:0] virt_addr;
    logic [4:0]  page_count;
    logic [63:0] entry_data;
    logic        read_error;
  } xptw_in_t;

  typedef struct packed {
    logic        kind;
    logic [51:0] read_addr;
    logic        read_wide;
    logic [39:0] frame_number;
    logic        fault;
    logic        last;
  } xptw_out_t;

  localparam int MaxPagesDef = 16;

  localparam logic CmdTranslate = 1'b0;
  localparam logic CmdEntry     = 1'b1;

  localparam logic KindRead   = 1'b0;
  localparam logic KindResult = 1'b1;

  localparam logic [1:0] CfgPaging = 2'd0;
  localparam logic [1:0] CfgLevels = 2'd1;
  localparam logic [1:0] CfgRoot   = 2'd2;

  localparam logic [47:0] MaskL4 = 48'hff80_0000_0000;
  localparam logic [47:0] MaskL3 = 48'h007f_c000_0000;
  localparam logic [47:0] MaskL2 = 48'h0000_ffc0_0000;
  localparam logic [5:0]  ShL4   = 6'd39;
  localparam logic [5:0]  ShL3   = 6'd30;
  localparam logic [5:0]  ShL2   = 6'd22;

  localparam logic [51:0] EntryFrame = 52'hf_ffff_ffff_f000;
  localparam logic [51:0] RootPae    = 52'hf_ffff_ffff_ffe0;
  localparam logic [51:0] RootPage   = 52'hf_ffff_ffff_f000;
  localparam int          LargeBit   = 7;
  localparam logic [47:0] PageBytes  = 48'h1000;

endpackage

@@ hdl/x86_page_table_walker_top.sv @@
// x86 page table walker: maps a run of 4 KiB virtual pages to frame numbers.
// Input channel (in_valid_i / in_stall_o / in_data_i) carries two kinds of beat:
// a translate command (start address, page count) and a returned table entry.
// Output channel (out_valid_o / out_stall_i / out_data_o) carries entry read
// requests (kind 0) and translation results (kind 1, last on the final page).
// The configuration port (cfg_we_i, cfg_index_i, cfg_data_i) sets paging on/off,
// table levels and the root register; write it while no beat is in flight.
// Each input beat is handled combinationally and its first result appears in
// the output register on the next cycle. A beat yields at most two results
// while walking (a page result and the next page's first read), so the block
// takes one beat per cycle while the receiver does not stall, holding the
// input while that read goes out if a page finishes mid-range. With paging off
// a translate beat yields one result per page, one per cycle unless stalled,
// and the input stalls until the run is out. Memory latency between a read
// request and its returned entry bounds the walk rate. When the receiver stalls,
// the output register holds and in_stall_o rises. Reset clears the walk, drops
// pending results and restores 2 levels, paging off and root zero.
module x86_page_table_walker_top
  import xptw_pkg::*;
#(
  parameter int MAX_PAGES = MaxPagesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  xptw_in_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output xptw_out_t   out_data_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [51:0] cfg_data_i
);

  logic        paging_q;
  logic [2:0]  levels_q;
  logic [51:0] root_q;

  logic        busy_q, busy_d;
  logic [2:0]  walk_lvl_q, walk_lvl_d;
  logic [47:0] mask_q, mask_d;
  logic [5:0]  sh_q, sh_d;
  logic [47:0] cv_q, cv_d;
  logic [4:0]  left_q, left_d;

  logic        out_valid_q;
  xptw_out_t   out_q;
  logic        pend_rd_q;
  logic [51:0] pend_addr_q;
  logic        pend_wide_q;
  logic [4:0]  run_cnt_q;
  logic [39:0] run_frame_q;

  logic        out_free, in_acc;
  logic [2:0]  lv;
  logic        wide;
  logic [51:0] root_aligned;
  logic [47:0] start_mask;
  logic [5:0]  start_sh;
  logic [5:0]  step;
  logic [47:0] mask_sh;
  logic [5:0]  nsh;
  logic [51:0] low52;
  logic [47:0] pv_old;
  logic [47:0] cv_next;
  logic [51:0] ent_base;
  logic [4:0]  cnt;

  logic        res0_v, res0_rd;
  xptw_out_t   res0;
  logic        pend_set;
  logic [51:0] pend_addr_n;
  logic        run_set;
  logic [4:0]  run_cnt_n;
  logic [39:0] run_frame_n;
  logic        fin, fin_fault;
  logic [39:0] fin_frame;
  logic [51:0] rd_base;
  logic [47:0] rd_mask;
  logic [5:0]  rd_sh;
  logic [47:0] rd_cv;
  logic [47:0] rd_pv;
  logic [9:0]  rd_idx;
  logic [51:0] rd_addr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      paging_q <= 1'b0;
      levels_q <= 3'd2;
      root_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgPaging: paging_q <= cfg_data_i[0];
        CfgLevels: levels_q <= cfg_data_i[2:0];
        CfgRoot:   root_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (levels_q < 3'd2) begin
      lv = 3'd2;
    end else if (levels_q > 3'd4) begin
      lv = 3'd4;
    end else begin
      lv = levels_q;
    end
  end

  assign wide         = (lv != 3'd2);
  assign root_aligned = (lv == 3'd3) ? (root_q & RootPae) : (root_q & RootPage);
  assign start_mask   = (lv == 3'd4) ? MaskL4 : ((lv == 3'd3) ? MaskL3 : MaskL2);
  assign start_sh     = (lv == 3'd4) ? ShL4 : ((lv == 3'd3) ? ShL3 : ShL2);
  assign step         = wide ? 6'd9 : 6'd10;
  assign mask_sh      = mask_q >> step;
  assign nsh          = (sh_q >= step) ? (sh_q - step) : 6'd0;
  assign low52        = (mask_q == '0) ? '1 : ((52'd1 << sh_q) - 52'd1);
  assign pv_old       = (lv == 3'd4) ? cv_q : {16'b0, cv_q[31:0]};
  assign cv_next      = cv_q + PageBytes;
  assign ent_base     = in_data_i.entry_data[51:0] & EntryFrame;
  assign cnt          = (int'(in_data_i.page_count) > MAX_PAGES) ? 5'(MAX_PAGES)
                                                                 : in_data_i.page_count;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = pend_rd_q || (run_cnt_q != '0) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    busy_d      = busy_q;
    walk_lvl_d  = walk_lvl_q;
    mask_d      = mask_q;
    sh_d        = sh_q;
    cv_d        = cv_q;
    left_d      = left_q;
    res0_v      = 1'b0;
    res0_rd     = 1'b0;
    res0        = '0;
    pend_set    = 1'b0;
    run_set     = 1'b0;
    run_cnt_n   = '0;
    run_frame_n = '0;
    fin         = 1'b0;
    fin_fault   = 1'b0;
    fin_frame   = '0;
    rd_base     = root_aligned;
    rd_mask     = start_mask;
    rd_sh       = start_sh;
    rd_cv       = in_data_i.virt_addr;

    if (in_acc) begin
      if (in_data_i.command == CmdTranslate) begin
        if (!busy_q && cnt != '0) begin
          res0_v = 1'b1;
          if (!paging_q) begin
            res0.kind         = KindResult;
            res0.frame_number = {4'b0, in_data_i.virt_addr[47:12]};
            res0.last         = (cnt == 5'd1);
            if (cnt > 5'd1) begin
              run_set     = 1'b1;
              run_cnt_n   = cnt - 5'd1;
              run_frame_n = {4'b0, in_data_i.virt_addr[47:12]} + 40'd1;
            end
          end else begin
            cv_d       = in_data_i.virt_addr;
            left_d     = cnt;
            busy_d     = 1'b1;
            walk_lvl_d = lv;
            mask_d     = start_mask;
            sh_d       = start_sh;
            res0_rd    = 1'b1;
          end
        end
      end else if (busy_q) begin
        if (in_data_i.read_error || !in_data_i.entry_data[0]) begin
          fin       = 1'b1;
          fin_fault = 1'b1;
        end else if (walk_lvl_q == 3'd2 && in_data_i.entry_data[LargeBit]) begin
          fin       = 1'b1;
          fin_frame = 40'(((ent_base & ~low52) | ({4'b0, pv_old} & low52)) >> 12);
        end else begin
          mask_d     = mask_sh;
          sh_d       = nsh;
          walk_lvl_d = walk_lvl_q - 3'd1;
          if (walk_lvl_q == 3'd1) begin
            fin       = 1'b1;
            fin_frame = ent_base[51:12];
          end else begin
            res0_v  = 1'b1;
            res0_rd = 1'b1;
            rd_base = ent_base;
            rd_mask = mask_sh;
            rd_sh   = nsh;
            rd_cv   = cv_q;
          end
        end
        if (fin) begin
          res0_v            = 1'b1;
          res0.kind         = KindResult;
          res0.frame_number = fin_frame;
          res0.fault        = fin_fault;
          res0.last         = (left_q <= 5'd1);
          left_d            = (left_q == '0) ? '0 : left_q - 5'd1;
          cv_d              = cv_next;
          if (left_q <= 5'd1) begin
            busy_d     = 1'b0;
            walk_lvl_d = '0;
          end else begin
            walk_lvl_d = lv;
            mask_d     = start_mask;
            sh_d       = start_sh;
            rd_cv      = cv_next;
            pend_set   = 1'b1;
          end
        end
      end
    end

    rd_pv       = (lv == 3'd4) ? rd_cv : {16'b0, rd_cv[31:0]};
    rd_idx      = 10'((rd_pv & rd_mask) >> rd_sh);
    rd_addr     = rd_base + (wide ? {39'b0, rd_idx, 3'b0} : {40'b0, rd_idx, 2'b0});
    pend_addr_n = rd_addr;
    if (res0_rd) begin
      res0.kind      = KindRead;
      res0.read_addr = rd_addr;
      res0.read_wide = wide;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      walk_lvl_q <= '0;
      mask_q     <= '0;
      sh_q       <= '0;
      cv_q       <= '0;
      left_q     <= '0;
    end else begin
      busy_q     <= busy_d;
      walk_lvl_q <= walk_lvl_d;
      mask_q     <= mask_d;
      sh_q       <= sh_d;
      cv_q       <= cv_d;
      left_q     <= left_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_rd_q   <= 1'b0;
      run_cnt_q   <= '0;
    end else if (out_free) begin
      if (pend_rd_q) begin
        out_valid_q <= 1'b1;
        pend_rd_q   <= 1'b0;
      end else if (run_cnt_q != '0) begin
        out_valid_q <= 1'b1;
        run_cnt_q   <= run_cnt_q - 5'd1;
      end else begin
        out_valid_q <= res0_v;
        pend_rd_q   <= pend_set;
        if (run_set) begin
          run_cnt_q <= run_cnt_n;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (pend_rd_q) begin
        out_q           <= '0;
        out_q.kind      <= KindRead;
        out_q.read_addr <= pend_addr_q;
        out_q.read_wide <= pend_wide_q;
      end else if (run_cnt_q != '0) begin
        out_q              <= '0;
        out_q.kind         <= KindResult;
        out_q.frame_number <= run_frame_q;
        out_q.last         <= (run_cnt_q == 5'd1);
        run_frame_q        <= run_frame_q + 40'd1;
      end else begin
        if (res0_v) begin
          out_q <= res0;
        end
        if (pend_set) begin
          pend_addr_q <= pend_addr_n;
          pend_wide_q <= wide;
        end
        if (run_set) begin
          run_frame_q <= run_frame_n;
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_busy_has_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (walk_lvl_q != '0 && left_q != '0))
    else $error("walk busy with no level or no pages left");

  a_pend_behind_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_rd_q |-> (out_valid_q && busy_q && out_q.kind == KindResult))
    else $error("pending read without a page result ahead of it");

  a_run_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_cnt_q != '0) |-> (out_valid_q && out_q.kind == KindResult && !out_q.last))
    else $error("identity run continues past a last beat");

  a_read_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.kind == KindRead) |-> busy_q)
    else $error("read request shown with no walk in progress");
`endif

endmodule
